/* rtl/core/polled_key_debounce_events_macros.svh */
// assertion macros shared by the debounce event block
`ifndef POLLED_KEY_DEBOUNCE_EVENTS_MACROS_SVH
`define POLLED_KEY_DEBOUNCE_EVENTS_MACROS_SVH

// same-cycle implication, checked out of reset
`define PKDB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PKDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pkdb_pkg.sv */
// shared constants, register codes and types of the debounce event block
package pkdb_pkg;

    localparam int NUM_BUTTONS      = 3;
    localparam int BTN_W            = 2;
    localparam int PIN_W            = 3;
    localparam int TIME_W           = 32;
    localparam int CNT_W            = 8;
    localparam int SEC_W            = 26;
    localparam int TICKS_PER_SECOND = 100;

    // seconds = (ticks * SEC_RECIP) >> SEC_RECIP_SHIFT, exact over 32-bit ticks
    localparam int SEC_RECIP_SHIFT = 37;
    localparam logic [TIME_W-1:0] SEC_RECIP =
        32'(((64'd1 << SEC_RECIP_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) /
            64'(TICKS_PER_SECOND));

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam int FIFO_DEPTH = NUM_BUTTONS + 1;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [TIME_W-1:0] last_time;
        logic [CNT_W-1:0]  count;
        logic              known;
        logic              stable;
    } t_btn_state;

    typedef struct packed {
        logic              last;
        logic [SEC_W-1:0]  secs;
        logic              is_switch;
        logic              pressed;
        logic [BTN_W-1:0]  button_index;
    } t_event;

endpackage

/* rtl/core/pkdb_state_mem.sv */
// per-button state memory with registered read and per-entry valid bits
module pkdb_state_mem
    import pkdb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [BTN_W-1:0] i_rd_addr,
    output t_btn_state       o_rd_data,
    input  logic             i_wr_en,
    input  logic [BTN_W-1:0] i_wr_addr,
    input  t_btn_state       i_wr_data
);

    t_btn_state r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_valid;
    t_btn_state r_rd_data;
    logic r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // an entry never written reads as the reset state
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* rtl/core/pkdb_sec_div.sv */
// registered tick-to-seconds divider by reciprocal multiplication
module pkdb_sec_div
    import pkdb_pkg::*;
(
    input  logic              i_clk,
    input  logic [TIME_W-1:0] i_ticks,
    output logic [SEC_W-1:0]  o_secs
);

    logic [2*TIME_W-1:0] prod;
    logic [SEC_W-1:0]    r_secs;

    always_comb begin
        prod = 64'(i_ticks) * 64'(SEC_RECIP);
    end

    always_ff @(posedge i_clk) begin
        r_secs <= prod[SEC_RECIP_SHIFT +: SEC_W];
    end

    assign o_secs = r_secs;

endmodule

/* rtl/core/pkdb_evt_fifo.sv */
// small event queue that feeds the output stream
module pkdb_evt_fifo
    import pkdb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_event                i_push_data,
    output logic                  o_valid,
    input  logic                  i_pop,
    output t_event                o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_event r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/polled_key_debounce_events.sv */
// top level of the polled key debouncer that reports button events
//
// One input word is one poll: the raw pin levels of the three buttons and the
// current tick time. The block walks the buttons in index order through a
// read-modify-write pass over its state memory, debounces each pin against
// the debounce threshold and emits one output word per accepted change,
// carrying the button, its new level, its switch flag and the whole seconds
// since that button's previous event. tlast marks the final word of a poll.
// Registers are written over the config channel, which is always ready.
// The next poll can be taken once the three memory reads, issued back to
// back, and then the update, divide and queue stages of the last button
// are done. Events wait in a four-word queue; when the receiver stalls
// the queue fills and s_axis_tready stays low until there is room for
// the three events a poll may cause. Reset restores the register
// defaults, marks all button state unknown and empties the queue.
`include "polled_key_debounce_events_macros.svh"

module polled_key_debounce_events
    import pkdb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pin_levels, now_ticks, zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // button_index, pressed, is_switch,
                                                  // seconds_since_last, zero pad
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [PIN_W-1:0] r_active_low;
    logic [PIN_W-1:0] r_switch;
    logic [CNT_W-1:0] r_threshold;

    logic              r_busy;
    logic              r_rd_act;
    logic [BTN_W-1:0]  r_rd_idx;
    logic [PIN_W-1:0]  r_pins;
    logic [TIME_W-1:0] r_now;

    logic             r_a_vld;
    logic [BTN_W-1:0] r_a_idx;

    logic              r_b_vld;
    logic [BTN_W-1:0]  r_b_idx;
    logic              r_b_ev;
    logic              r_b_lvl;
    logic              r_b_sw;
    logic [TIME_W-1:0] r_b_diff;

    logic             r_c_vld;
    logic [BTN_W-1:0] r_c_idx;
    logic             r_c_ev;
    logic             r_c_lvl;
    logic             r_c_sw;

    logic   r_flush;
    logic   r_pend_vld;
    t_event r_pend;

    logic             in_acc;
    logic             mem_rd_en;
    logic [BTN_W-1:0] mem_rd_addr;
    t_btn_state       mem_rd_data;
    t_btn_state       upd;
    logic             a_lvl;
    logic             a_sw;
    logic             a_changed;
    logic             a_ev;

    logic [SEC_W-1:0]      c_secs;
    logic                  c_ev;
    t_event                c_event;
    logic                  fifo_push;
    t_event                fifo_push_data;
    logic                  fifo_valid;
    t_event                fifo_data;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] fifo_load;

    // config channel
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= 3'd7;
            r_switch     <= 3'd0;
            r_threshold  <= 8'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[PIN_W-1:0];
                CFG_SWITCH:     r_switch     <= i_cfg_data[PIN_W-1:0];
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // poll intake and read sequencing
    assign fifo_load     = fifo_count + FIFO_CNT_W'(r_pend_vld);
    assign s_axis_tready = !r_busy && (fifo_load <= FIFO_CNT_W'(FIFO_DEPTH - NUM_BUTTONS));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign mem_rd_en     = in_acc || r_rd_act;
    assign mem_rd_addr   = in_acc ? '0 : r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pins <= s_axis_tdata[PIN_W-1:0];
            r_now  <= s_axis_tdata[PIN_W +: TIME_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_act <= 1'b0;
            r_rd_idx <= '0;
            r_flush  <= 1'b0;
        end else begin
            r_flush <= r_c_vld && (r_c_idx == BTN_W'(NUM_BUTTONS - 1));
            if (in_acc) begin
                r_busy   <= 1'b1;
            end else if (r_c_vld && (r_c_idx == BTN_W'(NUM_BUTTONS - 1))) begin
                r_busy   <= 1'b0;
            end
            if (in_acc) begin
                r_rd_act <= 1'b1;
                r_rd_idx <= BTN_W'(1);
            end else if (r_rd_act) begin
                if (r_rd_idx == BTN_W'(NUM_BUTTONS - 1)) begin
                    r_rd_act <= 1'b0;
                end
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    pkdb_state_mem u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (r_a_vld),
        .i_wr_addr (r_a_idx),
        .i_wr_data (upd)
    );

    // update stage: debounce one button and write its state back
    always_comb begin
        a_lvl     = r_pins[r_a_idx] ^ r_active_low[r_a_idx];
        a_sw      = r_switch[r_a_idx];
        a_changed = !mem_rd_data.known || (a_lvl != mem_rd_data.stable);
        a_ev      = 1'b0;
        upd       = mem_rd_data;
        if (a_changed && (mem_rd_data.count < r_threshold)) begin
            upd.count = mem_rd_data.count + CNT_W'(1);
        end else begin
            upd.count = '0;
            if (a_changed) begin
                a_ev       = mem_rd_data.known || a_sw;
                upd.stable = a_lvl;
                upd.known  = 1'b1;
                if (a_ev) begin
                    upd.last_time = r_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= mem_rd_en;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx  <= mem_rd_addr;
        r_b_idx  <= r_a_idx;
        r_b_ev   <= a_ev;
        r_b_lvl  <= a_lvl;
        r_b_sw   <= a_sw;
        r_b_diff <= r_now - mem_rd_data.last_time;
        r_c_idx  <= r_b_idx;
        r_c_ev   <= r_b_ev;
        r_c_lvl  <= r_b_lvl;
        r_c_sw   <= r_b_sw;
    end

    pkdb_sec_div u_sec_div (
        .i_clk   (i_clk),
        .i_ticks (r_b_diff),
        .o_secs  (c_secs)
    );

    // one event held back so the final one of a poll can carry tlast
    assign c_ev = r_c_vld && r_c_ev;

    always_comb begin
        c_event.last         = 1'b0;
        c_event.secs         = c_secs;
        c_event.is_switch    = r_c_sw;
        c_event.pressed      = r_c_lvl;
        c_event.button_index = r_c_idx;
        fifo_push            = (r_flush || c_ev) && r_pend_vld;
        fifo_push_data       = r_pend;
        fifo_push_data.last  = r_flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (c_ev) begin
            r_pend_vld <= 1'b1;
        end else if (r_flush) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ev) begin
            r_pend <= c_event;
        end
    end

    pkdb_evt_fifo u_evt_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fifo_push),
        .i_push_data (fifo_push_data),
        .o_valid     (fifo_valid),
        .i_pop       (m_axis_tready),
        .o_data      (fifo_data),
        .o_count     (fifo_count)
    );

    assign m_axis_tvalid = fifo_valid;
    assign m_axis_tlast  = fifo_data.last;
    assign m_axis_tdata  = {(OUT_TDATA_W - SEC_W - BTN_W - 2)'(0), fifo_data.secs,
                            fifo_data.is_switch, fifo_data.pressed,
                            fifo_data.button_index};

    `PKDB_ASSERT_NOW(a_no_rw_clash, mem_rd_en && r_a_vld, mem_rd_addr != r_a_idx, "state read and write hit the same entry")
    `PKDB_ASSERT_NOW(a_no_fifo_overflow, fifo_push, fifo_count < FIFO_CNT_W'(FIFO_DEPTH), "event queue overflow")
    `PKDB_ASSERT_NOW(a_update_in_poll, r_a_vld, r_busy, "state update outside a poll")
    `PKDB_ASSERT_NEXT(a_flush_after_last, r_c_vld && (r_c_idx == BTN_W'(NUM_BUTTONS - 1)), r_flush && !r_c_vld, "poll end not followed by flush")

endmodule
